@@ src/qfts_pkg.sv @@
// ----------------------------------------------------------------------------
// qfts_pkg
// Shared types and constants for the two-stack queue.
// ----------------------------------------------------------------------------
package qfts_pkg;

    localparam int DATA_W = 32;
    localparam int CAP_W  = 6;

    localparam logic [CAP_W-1:0] CAP_RESET = 6'd20;

    // register index of capacity in the config map
    localparam logic REG_CAPACITY = 1'b0;

    typedef logic [1:0] t_cmd;

    localparam t_cmd CMD_ENQ  = 2'd0;
    localparam t_cmd CMD_DEQ  = 2'd1;
    localparam t_cmd CMD_PEEK = 2'd2;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              was_empty;
        logic              overflow;
    } t_result;

endpackage

@@ src/queue_from_two_stacks_unit.sv @@
// ----------------------------------------------------------------------------
// queue_from_two_stacks_unit
// FIFO queue built from two bounded stacks, with a capacity register.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake            Contents
//  s         in   i_s_tvalid/o_s_tready tuser: command, tdata: value
//  m         out  o_m_tvalid/i_m_tready tdata: data, tuser: was_empty, overflow
//  apb       in   psel/penable/pready   capacity at address 0
//
//  Enqueue and unused command: IDLE, EXEC, DONE, then the output register.
//  Dequeue/peek with outbound stack occupied: EXEC, POPW, DONE.
//  Dequeue/peek needing a transfer: XRD then XWR per inbound entry, then POPR,
//  POPW, DONE; the registered inbound read splits each move into XRD and XWR.
//  One item at a time; o_s_tready is low until the result is handed to the
//  output register. Synchronous reset empties both stacks, capacity 20.
// ----------------------------------------------------------------------------
module queue_from_two_stacks_unit #(
    parameter int DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] value
    input  logic [1:0]  i_s_tuser,   // [1:0] command
    // output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] data
    output logic [1:0]  o_m_tuser,   // [0] was_empty, [1] overflow
    // config
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [qfts_pkg::CAP_W-1:0] r_capacity;
    logic                       cfg_wr;

    logic              res_valid;
    logic              res_ready;
    qfts_pkg::t_result res;

    logic                        r_m_tvalid;
    logic [qfts_pkg::DATA_W-1:0] r_m_data;
    logic [1:0]                  r_m_flags;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == qfts_pkg::REG_CAPACITY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= qfts_pkg::CAP_RESET;
        end else if (cfg_wr) begin
            r_capacity <= pwdata[qfts_pkg::CAP_W-1:0];
        end
    end

    assign prdata = (paddr[2] == qfts_pkg::REG_CAPACITY)
                  ? {{(32 - qfts_pkg::CAP_W){1'b0}}, r_capacity} : '0;

    qfts_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_capacity  (r_capacity),
        .i_cmd_valid (i_s_tvalid),
        .o_cmd_ready (o_s_tready),
        .i_cmd       (i_s_tuser),
        .i_value     (i_s_tdata),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // output register: frees the sequencer while the result waits
    assign res_ready = !r_m_tvalid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (res_ready) begin
            r_m_tvalid <= res_valid;
            if (res_valid) begin
                r_m_data  <= res.data;
                r_m_flags <= {res.overflow, res.was_empty};
            end
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_flags;

endmodule

@@ src/qfts_ram.sv @@
// ----------------------------------------------------------------------------
// qfts_ram
// Single-port-write, single-port-read stack storage with registered read.
// ----------------------------------------------------------------------------
module qfts_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ src/qfts_seq.sv @@
// ----------------------------------------------------------------------------
// qfts_seq
// Sequencer for the two-stack queue: holds both stack pointers, drives the
// two stack memories and performs the inbound-to-outbound transfer one
// element at a time.
// ----------------------------------------------------------------------------
module qfts_seq #(
    parameter int DEPTH = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [qfts_pkg::CAP_W-1:0] i_capacity,
    // command in
    input  logic                      i_cmd_valid,
    output logic                      o_cmd_ready,
    input  qfts_pkg::t_cmd            i_cmd,
    input  logic [qfts_pkg::DATA_W-1:0] i_value,
    // result out
    output logic                      o_res_valid,
    input  logic                      i_res_ready,
    output qfts_pkg::t_result         o_res
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > qfts_pkg::CAP_W) ? CW : qfts_pkg::CAP_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_XRD,
        S_XWR,
        S_POPR,
        S_POPW,
        S_DONE
    } t_state;

    t_state                      r_state;
    qfts_pkg::t_cmd              r_cmd;
    logic [qfts_pkg::DATA_W-1:0] r_value;
    logic [CW-1:0]               r_in_cnt;
    logic [CW-1:0]               r_out_cnt;
    qfts_pkg::t_result           r_res;

    logic [CW-1:0] in_top;
    logic [CW-1:0] out_top;
    logic [LW-1:0] cap_ext;
    logic [LW-1:0] depth_ext;
    logic [LW-1:0] limit;
    logic          enq_fits;
    logic          is_pop_cmd;
    logic          pop_direct;

    logic                        in_wr_en;
    logic                        in_rd_en;
    logic [qfts_pkg::DATA_W-1:0] in_rd_data;
    logic                        out_wr_en;
    logic                        out_rd_en;
    logic [qfts_pkg::DATA_W-1:0] out_rd_data;

    assign in_top    = r_in_cnt - 1'b1;
    assign out_top   = r_out_cnt - 1'b1;
    assign cap_ext   = LW'(i_capacity);
    assign depth_ext = LW'(DEPTH);
    assign limit     = (cap_ext > depth_ext) ? depth_ext : cap_ext;
    assign enq_fits  = LW'(r_in_cnt) < limit;

    assign is_pop_cmd = (r_cmd == qfts_pkg::CMD_DEQ) || (r_cmd == qfts_pkg::CMD_PEEK);
    assign pop_direct = is_pop_cmd && (r_out_cnt != '0);

    assign in_wr_en  = (r_state == S_EXEC) && (r_cmd == qfts_pkg::CMD_ENQ) && enq_fits;
    assign in_rd_en  = (r_state == S_XRD);
    assign out_wr_en = (r_state == S_XWR);
    // outbound read either straight from EXEC or after the transfer settles
    assign out_rd_en = ((r_state == S_EXEC) && pop_direct) || (r_state == S_POPR);

    qfts_ram #(
        .DEPTH (DEPTH),
        .WIDTH (qfts_pkg::DATA_W)
    ) u_inbound (
        .i_clk     (i_clk),
        .i_wr_en   (in_wr_en),
        .i_wr_addr (r_in_cnt[AW-1:0]),
        .i_wr_data (r_value),
        .i_rd_en   (in_rd_en),
        .i_rd_addr (in_top[AW-1:0]),
        .o_rd_data (in_rd_data)
    );

    qfts_ram #(
        .DEPTH (DEPTH),
        .WIDTH (qfts_pkg::DATA_W)
    ) u_outbound (
        .i_clk     (i_clk),
        .i_wr_en   (out_wr_en),
        .i_wr_addr (r_out_cnt[AW-1:0]),
        .i_wr_data (in_rd_data),
        .i_rd_en   (out_rd_en),
        .i_rd_addr (out_top[AW-1:0]),
        .o_rd_data (out_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_in_cnt  <= '0;
            r_out_cnt <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd   <= i_cmd;
                        r_value <= i_value;
                        r_res   <= '0;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (r_cmd == qfts_pkg::CMD_ENQ) begin
                        if (enq_fits) begin
                            r_in_cnt <= r_in_cnt + 1'b1;
                        end else begin
                            r_res.overflow <= 1'b1;
                        end
                        r_state <= S_DONE;
                    end else if (pop_direct) begin
                        r_state <= S_POPW;
                    end else if (is_pop_cmd && r_in_cnt != '0) begin
                        r_state <= S_XRD;
                    end else if (is_pop_cmd) begin
                        r_res.was_empty <= 1'b1;
                        r_state         <= S_DONE;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_XRD: begin
                    r_state <= S_XWR;
                end
                S_XWR: begin
                    r_in_cnt  <= r_in_cnt - 1'b1;
                    r_out_cnt <= r_out_cnt + 1'b1;
                    r_state   <= (r_in_cnt == CW'(1)) ? S_POPR : S_XRD;
                end
                S_POPR: begin
                    r_state <= S_POPW;
                end
                S_POPW: begin
                    r_res.data <= out_rd_data;
                    if (r_cmd == qfts_pkg::CMD_DEQ) begin
                        r_out_cnt <= r_out_cnt - 1'b1;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

    // pointers stay within the stacks
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_cnt <= CW'(DEPTH)) && (r_out_cnt <= CW'(DEPTH)))
        else $error("stack pointer beyond depth");

    // transfer only ever starts into an empty outbound stack
    a_xfer_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_cmd != qfts_pkg::CMD_ENQ && r_out_cnt != '0)
        |=> (r_state != S_XRD))
        else $error("transfer into non-empty outbound stack");

    // each transfer step conserves the element count
    a_xfer_conserve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_XWR) |=>
        (({1'b0, r_in_cnt} + {1'b0, r_out_cnt}) ==
         ($past({1'b0, r_in_cnt}) + $past({1'b0, r_out_cnt}))))
        else $error("element lost during transfer");

    // overflow only from an enqueue, and never alongside empty
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (!(r_res.overflow && r_res.was_empty) &&
                         (!r_res.overflow || r_cmd == qfts_pkg::CMD_ENQ)))
        else $error("inconsistent result flags");

endmodule
